// ----- design/dual_fenwick_tree_mod_sum_unit_assert.svh -----
// assertion macros shared by the fenwick sum unit rtl
// expects clk and rst in the scope where a macro is used
`ifndef DUAL_FENWICK_TREE_MOD_SUM_UNIT_ASSERT_SVH
`define DUAL_FENWICK_TREE_MOD_SUM_UNIT_ASSERT_SVH

// condition must hold whenever the antecedent holds, same cycle
`define DFTMS_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// condition must hold in the cycle after the antecedent
`define DFTMS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- design/dftms_pkg.sv -----
// shared types, codes and modular helpers for the fenwick sum unit
// no dependencies
package dftms_pkg;

  localparam int unsigned FIELD_W     = 13;
  localparam int unsigned DATA_W      = 30;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [DATA_W-1:0] PRIME = 30'd1000000007;

  // action codes, also used as command opcodes
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   op;
    logic               tree;
    logic [FIELD_W-1:0] idx_a;   // add position or upper prefix end
    logic [FIELD_W-1:0] idx_b;   // lower prefix end
    logic [DATA_W-1:0]  addend;
  } cmd_t;

  // a + b mod prime, both operands below 2^30 and their sum below 2 * prime
  function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[DATA_W-1:0];
  endfunction

  // a - b mod prime, both operands reduced
  function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

// ----- design/dftms_if.sv -----
// valid/ready channel interfaces for items and results
// depends on dftms_pkg
interface dftms_item_if;
  import dftms_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic               tree_select;
  logic [FIELD_W-1:0] position;
  logic [DATA_W-1:0]  addend;
  logic [FIELD_W-1:0] left_bound;
  logic [FIELD_W-1:0] right_bound;

  modport source (output valid, action, tree_select, position, addend, left_bound,
                  right_bound, input ready);
  modport sink (input valid, action, tree_select, position, addend, left_bound,
                right_bound, output ready);
endinterface

interface dftms_result_if;
  import dftms_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] range_total;

  modport source (output valid, range_total, input ready);
  modport sink (input valid, range_total, output ready);
endinterface

// ----- design/dual_fenwick_tree_mod_sum_unit.sv -----
// top level of the dual fenwick tree modular sum unit
// depends on dftms_pkg, dftms_if, dftms_front, dftms_queue, dftms_back
//
// Two binary indexed trees of TREE_SIZE entries each, every entry a partial sum
// modulo 1000000007. An add beat updates about log2(TREE_SIZE) entries of the
// selected tree, a query beat returns prefix(right) - prefix(left - 1) mod the
// prime as one result beat, and a clear beat zeroes both trees; adds, clears and
// action code 3 give no result. The front end classifies beats at one per cycle,
// unless the queue is full, into a four-entry queue, so input is taken while the
// back end works or while a result waits on the output register. The back end owns
// one simple dual-port tree memory per tree, one read and one write per cycle: an
// add reads and writes back each entry on its upward path, a query reads the
// entries given by the set bits of both bounds. After reset and for every clear
// beat the back end sweeps every entry of both memories, during which queued
// beats wait.
module dual_fenwick_tree_mod_sum_unit #(
  parameter int unsigned TREE_SIZE = 4096
) (
  input  logic           clk,
  input  logic           rst,
  dftms_item_if.sink     item,
  dftms_result_if.source result
);
  import dftms_pkg::*;

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic full;

  // queue to back
  cmd_t head;
  logic empty;
  logic pop;

  // classify beats, clamp bounds, drop no-ops
  dftms_front #(
    .TREE_SIZE (TREE_SIZE)
  ) u_front (
    .item (item),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  // decouples the accepting side from the tree walks
  dftms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // tree memories, walk sequencer and result register
  dftms_back #(
    .TREE_SIZE (TREE_SIZE)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ----- design/dftms_front.sv -----
// front end: accepts input beats, drops no-op items, clamps bounds, reduces addend
// depends on dftms_pkg and dftms_if
module dftms_front #(
  parameter int unsigned TREE_SIZE = 4096
) (
  dftms_item_if.sink        item,
  input  logic              full,
  output logic              push,
  output dftms_pkg::cmd_t   cmd
);
  import dftms_pkg::*;

  localparam int unsigned CW = ($clog2(TREE_SIZE + 1) > FIELD_W) ?
                               $clog2(TREE_SIZE + 1) : FIELD_W;
  localparam logic [CW-1:0] TS_C = CW'(TREE_SIZE);

  logic               accept;
  logic               keep;
  logic [FIELD_W-1:0] lower;
  logic [FIELD_W-1:0] hi_sat;
  logic [FIELD_W-1:0] lo_sat;

  assign item.ready = !full;
  assign accept     = item.valid && item.ready;

  always_comb begin
    lower  = (item.left_bound == '0) ? '0 : item.left_bound - FIELD_W'(1);
    hi_sat = (CW'(item.right_bound) > TS_C) ? TS_C[FIELD_W-1:0] : item.right_bound;
    lo_sat = (CW'(lower) > TS_C) ? TS_C[FIELD_W-1:0] : lower;

    case (item.action)
      ACT_ADD: begin
        keep = (item.position != '0) && (CW'(item.position) <= TS_C);
      end
      ACT_QUERY, ACT_CLEAR: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    cmd.op     = item.action;
    cmd.tree   = item.tree_select;
    cmd.idx_a  = (item.action == ACT_ADD) ? item.position : hi_sat;
    cmd.idx_b  = lo_sat;
    cmd.addend = mod_add(item.addend, '0);
  end

  assign push = accept && keep;

endmodule

// ----- design/dftms_queue.sv -----
// short command queue between front and back ends
// depends on dftms_pkg
module dftms_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dftms_pkg::cmd_t push_cmd,
  input  logic            pop,
  output dftms_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);
  import dftms_pkg::*;

  cmd_t              slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- design/dftms_back.sv -----
// back end: tree walks over the two tree memories, clearing sweep, result register
// depends on dftms_pkg, dftms_if and dual_fenwick_tree_mod_sum_unit_assert.svh
`include "dual_fenwick_tree_mod_sum_unit_assert.svh"

module dftms_back #(
  parameter int unsigned TREE_SIZE = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  dftms_pkg::cmd_t head,
  input  logic            empty,
  output logic            pop,
  dftms_result_if.source  result
);
  import dftms_pkg::*;

  localparam int unsigned AW = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
  localparam int unsigned WW = (($clog2(TREE_SIZE + 1) > FIELD_W) ?
                               $clog2(TREE_SIZE + 1) : FIELD_W) + 1;
  localparam logic [WW-1:0] TS_W   = WW'(TREE_SIZE);
  localparam logic [AW-1:0] LAST_A = AW'(TREE_SIZE - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_QRY  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state;
  logic [AW-1:0]     sweep;
  logic [WW-1:0]     walk_a;
  logic [WW-1:0]     walk_b;
  logic [DATA_W-1:0] acc_hi;
  logic [DATA_W-1:0] acc_lo;
  logic              cur_tree;
  logic [DATA_W-1:0] cur_addend;
  logic              rd_valid;
  logic              rd_lo;
  logic [AW-1:0]     rd_addr_q;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;

  logic [DATA_W-1:0] mem0 [TREE_SIZE];
  logic [DATA_W-1:0] mem1 [TREE_SIZE];
  logic [DATA_W-1:0] rd_data0;
  logic [DATA_W-1:0] rd_data1;

  logic [WW-1:0]     lsb_a;
  logic [WW-1:0]     lsb_b;
  logic [WW-1:0]     wa_m1;
  logic [WW-1:0]     wb_m1;
  logic              add_go;
  logic              hi_go;
  logic              lo_go;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] add_sum;
  logic              clr_we;
  logic              add_we;
  logic              we0;
  logic              we1;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              out_free;

  always_comb begin
    lsb_a   = walk_a & (~walk_a + WW'(1));
    lsb_b   = walk_b & (~walk_b + WW'(1));
    wa_m1   = walk_a - WW'(1);
    wb_m1   = walk_b - WW'(1);
    add_go  = (state == ST_ADD) && (walk_a <= TS_W);
    hi_go   = (state == ST_QRY) && (walk_a != '0);
    lo_go   = (state == ST_QRY) && (walk_a == '0) && (walk_b != '0);
    rd_en   = add_go || hi_go || lo_go;
    rd_addr = lo_go ? wb_m1[AW-1:0] : wa_m1[AW-1:0];
    rd_word = cur_tree ? rd_data1 : rd_data0;
    add_sum = mod_add(rd_word, cur_addend);
    clr_we  = (state == ST_CLR);
    add_we  = (state == ST_ADD) && rd_valid;
    we0     = clr_we || (add_we && !cur_tree);
    we1     = clr_we || (add_we && cur_tree);
    wr_addr = clr_we ? sweep : rd_addr_q;
    wr_data = clr_we ? '0 : add_sum;
  end

  assign pop                = (state == ST_IDLE) && !empty;
  assign out_free           = !out_valid || result.ready;
  assign result.valid       = out_valid;
  assign result.range_total = out_data;

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data0 <= mem0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data1 <= mem1[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      sweep     <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      // a new total may replace the one taken at this edge
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          if (sweep == LAST_A) begin
            sweep <= '0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + AW'(1);
          end
        end
        ST_IDLE: begin
          if (!empty) begin
            case (head.op)
              ACT_ADD:   state <= ST_ADD;
              ACT_QUERY: state <= ST_QRY;
              ACT_CLEAR: begin
                sweep <= '0;
                state <= ST_CLR;
              end
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_ADD: begin
          if (!add_go && !rd_valid) begin
            state <= ST_IDLE;
          end
        end
        ST_QRY: begin
          if (!hi_go && !lo_go && !rd_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    rd_lo     <= lo_go;
    rd_addr_q <= rd_addr;
    if (pop) begin
      cur_tree   <= head.tree;
      cur_addend <= head.addend;
      walk_a     <= WW'(head.idx_a);
      walk_b     <= WW'(head.idx_b);
      acc_hi     <= '0;
      acc_lo     <= '0;
    end else begin
      if (add_go) begin
        walk_a <= walk_a + lsb_a;
      end else if (hi_go) begin
        walk_a <= walk_a - lsb_a;
      end else if (lo_go) begin
        walk_b <= walk_b - lsb_b;
      end
      if ((state == ST_QRY) && rd_valid) begin
        if (rd_lo) begin
          acc_lo <= mod_add(acc_lo, rd_word);
        end else begin
          acc_hi <= mod_add(acc_hi, rd_word);
        end
      end
    end
    if ((state == ST_DONE) && out_free) begin
      out_data <= mod_sub(acc_hi, acc_lo);
    end
  end

  // a read result is only ever consumed inside a walk
  `DFTMS_IMPLIES(a_rd_in_walk, rd_valid, state == ST_ADD || state == ST_QRY)
  // pipelined add never reads the entry it is writing back
  `DFTMS_IMPLIES(a_no_rw_clash, add_we && add_go, rd_addr != rd_addr_q)
  // query result is formed only after both walks have drained
  `DFTMS_IMPLIES(a_done_drained, state == ST_DONE, !rd_valid && walk_a == '0 && walk_b == '0)
  // a dequeued command always starts work
  `DFTMS_NEXT(a_pop_starts, pop, state != ST_IDLE)

endmodule
